@@ rtl/aie_pkg.sv @@
// Package for the accumulator instruction execute core.
// Holds parameter defaults and operation codes; depends on nothing.
package aie_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned MEM_WORDS_DEF = 128;

  localparam int unsigned OP_BITS   = 4;
  localparam int unsigned ADDR_BITS = 7;
  localparam int unsigned PORT_BITS = 32;

  typedef enum logic [OP_BITS-1:0] {
    OP_PRINT  = 4'd0,
    OP_READ   = 4'd1,
    OP_LOAD   = 4'd2,
    OP_SAVE   = 4'd3,
    OP_ADD    = 4'd4,
    OP_SUB    = 4'd5,
    OP_DIV    = 4'd6,
    OP_MUL    = 4'd7,
    OP_JUMP   = 4'd8,
    OP_BRNEG  = 4'd9,
    OP_BRZERO = 4'd10,
    OP_HALT   = 4'd11
  } op_e;

endpackage

@@ rtl/accumulator_instruction_execute_core.sv @@
// Execute core of a one-accumulator teaching machine: accumulator, word memory,
// shared adder and its sequencer, output register. Depends on aie_pkg.
//
// Each beat is one decoded instruction. The block accepts one beat at a time
// and holds in_stall_o high while it works: a multiply and a divide by a
// non-zero word occupy it longest, since one adder steps the product or
// quotient one bit per cycle and the single memory port reads the operand
// first; every other beat, a divide by zero and any beat after a halt take
// the short path through the read, execute and done states. After reset the
// block clears the word memory, one word per cycle, before it takes the first
// beat. A finished result waits in the output register while the next beat is
// taken; a further result holds the core, and its input, until that register
// drains.
module accumulator_instruction_execute_core
  import aie_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [OP_BITS-1:0]          operation_i,
  input  logic [ADDR_BITS-1:0]        address_i,
  input  logic signed [PORT_BITS-1:0] read_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [PORT_BITS-1:0] print_value_o,
  output logic                        print_valid_o,
  output logic signed [PORT_BITS-1:0] accumulator_value_o,
  output logic                        branch_taken_o,
  output logic [ADDR_BITS-1:0]        branch_target_o,
  output logic                        halted_o,
  output logic                        divide_error_o
);

  localparam int unsigned WB = WORD_BITS;
  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned IW = (AW > ADDR_BITS) ? AW : ADDR_BITS;
  localparam int unsigned CW = $clog2(WORD_BITS);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_READ  = 10'b00_0000_0100,
    S_EXEC  = 10'b00_0000_1000,
    S_ABSA  = 10'b00_0001_0000,
    S_ABSB  = 10'b00_0010_0000,
    S_MUL   = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_SIGN  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          halt_q, halt_d;
  logic          out_valid_q, out_valid_d;

  logic [OP_BITS-1:0]   op_q, op_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic signed [WB-1:0] rdv_q, rdv_d;
  logic signed [WB-1:0] acc_q, acc_d;
  logic [WB-1:0]        x_q, x_d;
  logic [WB-1:0]        y_q, y_d;
  logic [WB-1:0]        z_q, z_d;
  logic                 neg_q, neg_d;

  logic signed [WB-1:0] r_pval_q, r_pval_d;
  logic                 r_pvalid_q, r_pvalid_d;
  logic                 r_btaken_q, r_btaken_d;
  logic                 r_derr_q, r_derr_d;

  logic signed [PORT_BITS-1:0] o_pval_q, o_acc_q;
  logic                        o_pvalid_q, o_btaken_q, o_halt_q, o_derr_q;
  logic [ADDR_BITS-1:0]        o_btarget_q;
  logic                        out_load;

  logic signed [WB-1:0] mem_q [MEM_WORDS];
  logic signed [WB-1:0] mem_rd_q;
  logic signed [WB-1:0] mem_val;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic signed [WB-1:0] mem_wd;
  logic [IW-1:0]        addr_ext;
  logic [AW-1:0]        addr_idx;
  logic                 in_range;

  logic [WB:0] alu_a, alu_b, alu_sum;
  logic        alu_inv;
  logic [WB:0] div_trial;

  assign addr_ext = IW'(addr_q);
  assign addr_idx = addr_ext[AW-1:0];
  assign in_range = (32'(addr_q) < MEM_WORDS);
  assign mem_val  = in_range ? mem_rd_q : '0;

  assign alu_sum   = alu_a + (alu_inv ? ~alu_b : alu_b) + (WB+1)'(alu_inv);
  assign div_trial = {x_q, z_q[WB-1]};

  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    cnt_d      = cnt_q;
    halt_d     = halt_q;
    out_valid_d = out_valid_q;
    op_d       = op_q;
    addr_d     = addr_q;
    rdv_d      = rdv_q;
    acc_d      = acc_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    neg_d      = neg_q;
    r_pval_d   = r_pval_q;
    r_pvalid_d = r_pvalid_q;
    r_btaken_d = r_btaken_q;
    r_derr_d   = r_derr_q;
    mem_we     = 1'b0;
    mem_wa     = addr_idx;
    mem_wd     = acc_q;
    alu_a      = '0;
    alu_b      = '0;
    alu_inv    = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_cnt_q;
        mem_wd    = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          addr_d  = address_i;
          rdv_d   = WB'(read_value_i);
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        r_pval_d   = '0;
        r_pvalid_d = 1'b0;
        r_btaken_d = 1'b0;
        r_derr_d   = 1'b0;
        state_d    = S_DONE;
        if (!halt_q) begin
          case (op_e'(op_q))
            OP_PRINT: begin
              r_pval_d   = mem_val;
              r_pvalid_d = 1'b1;
            end
            OP_READ: begin
              mem_we = in_range;
              mem_wd = rdv_q;
            end
            OP_LOAD: begin
              acc_d = mem_val;
            end
            OP_SAVE: begin
              mem_we = in_range;
              mem_wd = acc_q;
            end
            OP_ADD, OP_SUB: begin
              alu_a   = {1'b0, acc_q};
              alu_b   = {1'b0, mem_val};
              alu_inv = (op_e'(op_q) == OP_SUB);
              acc_d   = alu_sum[WB-1:0];
            end
            OP_DIV: begin
              if (mem_val == '0) begin
                r_derr_d = 1'b1;
              end else begin
                z_d     = acc_q;
                y_d     = mem_val;
                neg_d   = acc_q[WB-1] ^ mem_val[WB-1];
                state_d = S_ABSA;
              end
            end
            OP_MUL: begin
              x_d     = '0;
              y_d     = acc_q;
              z_d     = mem_val;
              cnt_d   = '0;
              state_d = S_MUL;
            end
            OP_JUMP: begin
              r_btaken_d = 1'b1;
            end
            OP_BRNEG: begin
              r_btaken_d = acc_q[WB-1];
            end
            OP_BRZERO: begin
              r_btaken_d = (acc_q == '0);
            end
            OP_HALT: begin
              halt_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_ABSA: begin
        alu_b   = {1'b0, z_q};
        alu_inv = 1'b1;
        if (z_q[WB-1]) begin
          z_d = alu_sum[WB-1:0];
        end
        state_d = S_ABSB;
      end
      S_ABSB: begin
        alu_b   = {1'b0, y_q};
        alu_inv = 1'b1;
        if (y_q[WB-1]) begin
          y_d = alu_sum[WB-1:0];
        end
        x_d     = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        alu_a   = div_trial;
        alu_b   = {1'b0, y_q};
        alu_inv = 1'b1;
        if (!alu_sum[WB]) begin
          x_d = alu_sum[WB-1:0];
        end else begin
          x_d = div_trial[WB-1:0];
        end
        z_d   = {z_q[WB-2:0], !alu_sum[WB]};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(WORD_BITS - 1)) begin
          state_d = S_SIGN;
        end
      end
      S_SIGN: begin
        alu_b   = {1'b0, z_q};
        alu_inv = 1'b1;
        acc_d   = neg_q ? alu_sum[WB-1:0] : z_q;
        state_d = S_DONE;
      end
      S_MUL: begin
        alu_a = {1'b0, x_q};
        alu_b = z_q[0] ? {1'b0, y_q} : '0;
        x_d   = alu_sum[WB-1:0];
        y_d   = {y_q[WB-2:0], 1'b0};
        z_d   = {1'b0, z_q[WB-1:1]};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(WORD_BITS - 1)) begin
          acc_d   = alu_sum[WB-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      cnt_q       <= cnt_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    rdv_q      <= rdv_d;
    x_q        <= x_d;
    y_q        <= y_d;
    z_q        <= z_d;
    neg_q      <= neg_d;
    r_pval_q   <= r_pval_d;
    r_pvalid_q <= r_pvalid_d;
    r_btaken_q <= r_btaken_d;
    r_derr_q   <= r_derr_d;
    if (out_load) begin
      o_pval_q    <= PORT_BITS'(r_pval_q);
      o_pvalid_q  <= r_pvalid_q;
      o_acc_q     <= PORT_BITS'(acc_q);
      o_btaken_q  <= r_btaken_q;
      o_btarget_q <= r_btaken_q ? addr_q : '0;
      o_halt_q    <= halt_q;
      o_derr_q    <= r_derr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem_q[addr_idx];
  end

  assign out_valid_o         = out_valid_q;
  assign print_value_o       = o_pval_q;
  assign print_valid_o       = o_pvalid_q;
  assign accumulator_value_o = o_acc_q;
  assign branch_taken_o      = o_btaken_q;
  assign branch_target_o     = o_btarget_q;
  assign halted_o            = o_halt_q;
  assign divide_error_o      = o_derr_q;

endmodule
